>>> src/srg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the subtractive random generator
// no dependencies

package srg_pkg;

   localparam int unsigned LAG_LEN = 55;
   localparam int unsigned IDX_W   = $clog2(LAG_LEN);

   typedef logic [27:0]      seed_type;
   typedef logic [29:0]      value_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [1:0]       round_type;

   localparam logic [30:0] RNG_MOD       = 31'd1000000000;
   localparam seed_type    RNG_SEED_BASE = 28'd161803398;
   localparam idx_type     FILL_STRIDE   = IDX_W'(21);
   localparam idx_type     LAST_IDX      = IDX_W'(LAG_LEN - 1);
   localparam idx_type     MIX_LAG_IDX   = IDX_W'(31);
   localparam round_type   LAST_ROUND    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_MIX,
      ST_READ,
      ST_WRITE
   } state_type;

   // (a - b) modulo 1e9, both operands below 1e9
   function automatic value_type sub_mod(input value_type a, input value_type b);
      logic [30:0] t;
      if (a >= b) begin
         t = {1'b0, a} - {1'b0, b};
      end else begin
         t = {1'b0, a} + RNG_MOD - {1'b0, b};
      end
      return t[29:0];
   endfunction

   // table index one step on, wrapping over the table
   function automatic idx_type idx_next(input idx_type i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   // table index plus the fill stride, wrapping over the table
   function automatic idx_type idx_stride(input idx_type i);
      logic [IDX_W:0] s;
      s = {1'b0, i} + {1'b0, FILL_STRIDE};
      if (s >= (IDX_W + 1)'(LAG_LEN)) begin
         s = s - (IDX_W + 1)'(LAG_LEN);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

>>> src/srg_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the subtractive random generator
// depends on srg_pkg

interface srg_req_if import srg_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     reseed;
   seed_type seed_value;

   modport source (output valid, output reseed, output seed_value, input ready);
   modport sink   (input valid, input reseed, input seed_value, output ready);
endinterface

interface srg_rsp_if import srg_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

>>> src/subtractive_random_generator_core.sv
`timescale 1ns / 1ps
// subtractive lagged-table random generator core, table held in a 55-entry memory
// depends on srg_pkg and the channel interfaces in srg_if
//
// usage
//   req_ch carries one request beat: reseed and seed_value. rsp_ch returns one
//   beat per request: random_value in 0..999999999.
//   req_ch.ready is high only while the core is idle; one request is in work
//   at a time.
//   a plain draw reads both table entries from the registered-read table
//   memory in the accept cycle; ST_WRITE then subtracts, writes the entry
//   back and loads the response register, waiting while that register is
//   full. the next request is taken once the core is back in ST_IDLE.
//   a draw that seeds (reseed set, or the first request after reset) runs
//   55 fill writes at stride 21, 220 mixing read-modify-writes (four rounds
//   at lag 31, pipelined one entry per cycle), then the draw.
//   seed_value above 161803398 is taken as 161803398.
//   reset clears the state machine, the seeded flag and the response valid;
//   the table is not cleared, the first request after reset seeds it.
//   when the receiver stalls, the response beat waits in its register; the
//   next request is still accepted and its draw waits in the write-back
//   cycle until the register frees.

module subtractive_random_generator_core
   import srg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   srg_req_if.sink    req_ch,
   srg_rsp_if.source  rsp_ch
);

   // lag table memory, two read ports and one write port
   value_type lag_mem [0:LAG_LEN-1];

   logic      rd_en;
   idx_type   rd_addr_a;
   idx_type   rd_addr_b;
   value_type rd_data_a_ff;
   value_type rd_data_b_ff;
   logic      wr_en;
   idx_type   wr_addr;
   value_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lag_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= lag_mem[rd_addr_a];
         rd_data_b_ff <= lag_mem[rd_addr_b];
      end
   end

   // control and working registers
   state_type state_ff, state_in;
   logic      seeded_ff, seeded_in;
   idx_type   rd_idx_ff, rd_idx_in;      // current pointer, as table index
   idx_type   lag_idx_ff, lag_idx_in;    // lagged pointer, as table index
   value_type cur_ff, cur_in;            // fill recurrence
   value_type prev_ff, prev_in;
   idx_type   fill_idx_ff, fill_idx_in;
   idx_type   fill_cnt_ff, fill_cnt_in;
   idx_type   mix_idx_ff, mix_idx_in;
   idx_type   mix_lag_ff, mix_lag_in;
   round_type round_ff, round_in;
   logic      mix_wr_ff, mix_wr_in;      // mixing write-back due this cycle
   idx_type   wb_addr_ff, wb_addr_in;    // write-back address of the last read issued
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_data_ff, rsp_data_in;

   value_type diff;
   seed_type  seed_sat;
   logic      req_fire;
   logic      rsp_free;

   assign diff     = sub_mod(rd_data_a_ff, rd_data_b_ff);
   assign seed_sat = (req_ch.seed_value > RNG_SEED_BASE) ? RNG_SEED_BASE
                                                         : req_ch.seed_value;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.random_value = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      rd_idx_in    = rd_idx_ff;
      lag_idx_in   = lag_idx_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      fill_idx_in  = fill_idx_ff;
      fill_cnt_in  = fill_cnt_ff;
      mix_idx_in   = mix_idx_ff;
      mix_lag_in   = mix_lag_ff;
      round_in     = round_ff;
      mix_wr_in    = 1'b0;
      wb_addr_in   = wb_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rd_en        = 1'b0;
      rd_addr_a    = rd_idx_ff;
      rd_addr_b    = lag_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = wb_addr_ff;
      wr_data      = diff;

      // pending mixing write-back, lands while the next entry is read
      if (mix_wr_ff) begin
         wr_en = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_in      = {2'b00, RNG_SEED_BASE - seed_sat};
               prev_in     = value_type'(1);
               fill_idx_in = LAST_IDX;
               fill_cnt_in = '0;
               if (req_ch.reseed || !seeded_ff) begin
                  state_in = ST_FILL;
               end else begin
                  rd_en      = 1'b1;
                  wb_addr_in = rd_idx_ff;
                  state_in   = ST_WRITE;
               end
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fill_idx_ff;
            if (fill_cnt_ff == '0) begin
               // last entry takes the seed term
               wr_data = cur_ff;
            end else begin
               wr_data = prev_ff;
               cur_in  = prev_ff;
               prev_in = sub_mod(cur_ff, prev_ff);
            end
            fill_idx_in = idx_stride(fill_idx_ff);
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == LAST_IDX) begin
               mix_idx_in = '0;
               mix_lag_in = MIX_LAG_IDX;
               round_in   = '0;
               state_in   = ST_MIX;
            end
         end
         ST_MIX: begin
            rd_en      = 1'b1;
            rd_addr_a  = mix_idx_ff;
            rd_addr_b  = mix_lag_ff;
            mix_wr_in  = 1'b1;
            wb_addr_in = mix_idx_ff;
            mix_idx_in = idx_next(mix_idx_ff);
            mix_lag_in = idx_next(mix_lag_ff);
            if (mix_idx_ff == LAST_IDX) begin
               round_in = round_ff + 1'b1;
               if (round_ff == LAST_ROUND) begin
                  seeded_in  = 1'b1;
                  rd_idx_in  = '0;
                  lag_idx_in = MIX_LAG_IDX;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            // last mixing write (entry 55) goes out alongside this read
            rd_en      = 1'b1;
            wb_addr_in = rd_idx_ff;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_free) begin
               wr_en        = 1'b1;
               rsp_data_in  = diff;
               rsp_valid_in = 1'b1;
               rd_idx_in    = idx_next(rd_idx_ff);
               lag_idx_in   = idx_next(lag_idx_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         mix_wr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         mix_wr_ff    <= mix_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      lag_idx_ff  <= lag_idx_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      fill_idx_ff <= fill_idx_in;
      fill_cnt_ff <= fill_cnt_in;
      mix_idx_ff  <= mix_idx_in;
      mix_lag_ff  <= mix_lag_in;
      round_ff    <= round_in;
      wb_addr_ff  <= wb_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/srg_checker.sv
`timescale 1ns / 1ps
// port-level checker for the subtractive random generator core, and its bind
// depends on srg_pkg and subtractive_random_generator_core

module srg_checker
   import srg_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input value_type rsp_value
);

   // drawn values stay below the modulus
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_value} < RNG_MOD))
      else $error("response value out of range");

   // one request in work at a time
   assert property (@(posedge clock)
      (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in work");

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response beat stays
   assert property (@(posedge clock)
      (!reset && rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // and holds its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_value))
      else $error("response value changed while stalled");

endmodule

bind subtractive_random_generator_core srg_checker u_srg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.random_value)
);

>>> tb/srg_draw_checker.sv
`timescale 1ns / 1ps
// draw checker: watches the request and response channels, predicts each draw
// depends on srg_pkg and the channel interfaces in srg_if

module srg_draw_checker
   import srg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   srg_req_if          req_mon,
   srg_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   localparam int unsigned MODULUS  = 1000000000;
   localparam int unsigned SEED_CAP = 161803398;
   localparam int unsigned TAB_LEN  = 55;
   localparam int unsigned STRIDE   = 21;
   localparam int unsigned MIX_LAG  = 30;
   localparam int unsigned DRAW_LAG = 31;

   // predicted generator state, table indexed by position 1..55
   value_type   lag_tab [1:TAB_LEN];
   int unsigned rd_pos;
   int unsigned lag_pos;
   bit          seeded;

   value_type   expected_draws [$];

   function automatic int unsigned diff_mod(input int unsigned a, input int unsigned b);
      if (a >= b) begin
         return a - b;
      end
      return a + MODULUS - b;
   endfunction

   function automatic int unsigned step_pos(input int unsigned p);
      if (p == 0 || p > TAB_LEN) begin
         p = TAB_LEN;
      end
      return (p == TAB_LEN) ? 1 : p + 1;
   endfunction

   function automatic void rebuild_table(input seed_type s);
      int unsigned cur;
      int unsigned prev;
      int unsigned nxt;
      int unsigned pos;
      cur = SEED_CAP - ((s > SEED_CAP) ? SEED_CAP : int'(s));
      lag_tab[TAB_LEN] = value_type'(cur);
      prev = 1;
      for (int i = 1; i < TAB_LEN; i++) begin
         pos = (STRIDE * i) % TAB_LEN;
         if (pos == 0) begin
            pos = TAB_LEN;
         end
         lag_tab[pos] = value_type'(prev);
         nxt  = diff_mod(cur, prev);
         cur  = prev;
         prev = nxt;
      end
      // four mixing rounds
      for (int k = 0; k < 4; k++) begin
         for (int i = 1; i <= TAB_LEN; i++) begin
            lag_tab[i] = value_type'(diff_mod(lag_tab[i], lag_tab[1 + (i + MIX_LAG) % TAB_LEN]));
         end
      end
      rd_pos  = 0;
      lag_pos = DRAW_LAG;
      seeded  = 1'b1;
   endfunction

   function automatic value_type draw_value(input logic rs, input seed_type s);
      value_type v;
      if (rs || !seeded) begin
         rebuild_table(s);
      end
      rd_pos  = step_pos(rd_pos);
      lag_pos = step_pos(lag_pos);
      v = value_type'(diff_mod(lag_tab[rd_pos], lag_tab[lag_pos]));
      lag_tab[rd_pos] = v;
      return v;
   endfunction

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      value_type want;
      if (reset) begin
         rd_pos  = 0;
         lag_pos = 0;
         seeded  = 1'b0;
         expected_draws.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected random_value beat, expected none, got %0d",
                        $time, rsp_mon.random_value);
               fail_count++;
            end else begin
               want = expected_draws.pop_front();
               if (rsp_mon.random_value !== want) begin
                  $display("%0t: random_value mismatch, expected %0d, got %0d",
                           $time, want, rsp_mon.random_value);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            // append the predicted draw at the tail of the queue
            want = draw_value(req_mon.reseed, req_mon.seed_value);
            expected_draws = {expected_draws, want};
         end
      end
      outstanding <= expected_draws.size();
   end

endmodule

>>> tb/tb_subtractive_random_generator_core.sv
`timescale 1ns / 1ps
// testbench top of the subtractive random generator core: stimulus and verdict
// depends on srg_pkg, srg_if, the core and srg_draw_checker

module tb_subtractive_random_generator_core;
   import srg_pkg::*;

   localparam int unsigned SEED_CAP     = 161803398;
   localparam int unsigned PHASE_DRAWS  = 383;
   localparam int unsigned SETTLE_CYCLES = 300;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned outstanding;

   // idling odds in percent, changed per phase
   int unsigned idle_pct;
   int unsigned stall_pct;

   srg_req_if req_ch ();
   srg_rsp_if rsp_ch ();

   subtractive_random_generator_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   srg_draw_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // receiver side: ready redrawn every cycle at the current stall odds
   always @(posedge clock) begin
      rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // one request beat; valid is left high after acceptance so that back-to-back
   // beats never lower and raise it within one step
   task automatic send_request(input logic rs, input seed_type sv);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.reseed     <= rs;
      req_ch.seed_value <= sv;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // hold the sender off until every draw in flight has come back
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // seed magnitudes: full-width or up to the cap, with weight on small seeds and the saturation edge
   function automatic seed_type pick_seed;
      case ($urandom_range(7))
         0, 1, 2: return seed_type'($urandom());
         3, 4:    return seed_type'($urandom_range(SEED_CAP));
         5:       return seed_type'($urandom_range(100));
         default: return seed_type'($urandom_range(SEED_CAP + 50, SEED_CAP - 50));
      endcase
   endfunction

   // random draws: reseeds are rare since each rebuild runs the full fill and mixing pass
   task automatic random_phase(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         send_request($urandom_range(99) < 5, pick_seed());
      end
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      idle_pct          = 0;
      stall_pct         = 0;
      req_ch.valid      = 1'b0;
      req_ch.reseed     = 1'b0;
      req_ch.seed_value = '0;
      rsp_ch.ready      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first draw seeds itself even without reseed
      send_request(1'b0, seed_type'(12345));
      send_request(1'b0, seed_type'($urandom()));
      send_request(1'b0, '1);
      send_request(1'b0, '0);
      // smallest seeds, seeds at and next to the cap, and seeds that saturate
      send_request(1'b1, '0);
      send_request(1'b0, seed_type'($urandom()));
      send_request(1'b1, seed_type'(SEED_CAP));
      send_request(1'b0, seed_type'($urandom()));
      send_request(1'b1, seed_type'(SEED_CAP + 1));
      send_request(1'b1, '1);
      send_request(1'b1, seed_type'(SEED_CAP - 1));
      send_request(1'b1, seed_type'(1));
      // alternating bit patterns on the seed
      send_request(1'b1, 28'h5555555);
      send_request(1'b1, 28'hAAAAAAA);
      // plain draws after the last reseed, short of the pointers' wrap point
      for (int i = 0; i < 8; i++) begin
         send_request(1'b0, seed_type'($urandom()));
      end
      drain();

      // free-running, no idling on either side
      random_phase(PHASE_DRAWS);
      drain();

      // sender mostly idle
      idle_pct = 72;
      random_phase(PHASE_DRAWS);
      drain();

      // receiver mostly stalling
      idle_pct  = 0;
      stall_pct = 72;
      random_phase(PHASE_DRAWS);
      drain();

      // light idling on both sides
      idle_pct  = 18;
      stall_pct = 18;
      random_phase(PHASE_DRAWS);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, well beyond a run where every draw reseeds and every beat stalls
   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
